// File: sv/sva_pkg.sv
// Shared types, constants and coefficient tables for the stencil differentiator.
`timescale 1ns / 1ps

package sva_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_W     = 3;
   localparam int POS_W    = 32;
   localparam int VEL_W    = 48;
   localparam int ACC_W    = 56;
   localparam int FS_W     = 11;

   localparam logic [FS_W-1:0] FS_RESET = FS_W'(100);

   // window geometry: nine taps per channel, slot index 0..8
   localparam int WIN     = 9;
   localparam int SLOT_W  = 4;
   localparam int SEEN_W  = 4;
   localparam int ADDR_W  = CH_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   localparam logic [SEEN_W-1:0] SEEN_FULL  = SEEN_W'(WIN);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WIN - 1);
   localparam logic [SLOT_W-1:0] CENTRE_TAP = SLOT_W'(4);

   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] HEAD_COPIES = CNT_W'(5);
   localparam logic [CNT_W-1:0] TAIL_COPIES = CNT_W'(4);

   // stencil sums
   localparam int S1_W = 37;
   localparam int S2_W = 42;
   localparam int M1_W = 36;
   localparam int M2_W = 40;

   localparam logic signed [4:0] VEL_COEF [WIN] = '{
      5'sd0, 5'sd0, 5'sd1, -5'sd8, 5'sd0, 5'sd8, -5'sd1, 5'sd0, 5'sd0
   };
   localparam logic signed [8:0] ACC_COEF [WIN] = '{
      9'sd1, -9'sd16, 9'sd64, 9'sd16, -9'sd130, 9'sd16, 9'sd64, -9'sd16, 9'sd1
   };

   // shared multiplier and radix-4 divider
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 22;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int WORK_W  = 64;
   localparam int REM_W   = 8;
   localparam int TRIAL_W = REM_W + 2;
   localparam int DIV_STEPS = WORK_W / 2;
   localparam int STEP_W  = 5;

   localparam logic [REM_W-1:0] VEL_DIV  = REM_W'(12);
   localparam logic [REM_W-1:0] ACC_DIV  = REM_W'(144);
   localparam logic [WORK_W-1:0] VEL_HALF = WORK_W'(6);
   localparam logic [WORK_W-1:0] ACC_HALF = WORK_W'(72);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   typedef logic signed [S1_W-1:0] s1_type;
   typedef logic signed [S2_W-1:0] s2_type;

   typedef struct packed {
      logic                    done;
      logic signed [VEL_W-1:0] velocity;
      logic signed [ACC_W-1:0] acceleration;
   } arith_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_CHECK,
      ST_TAP,
      ST_LAUNCH,
      ST_ARITH,
      ST_RESULT,
      ST_NEXT
   } seq_state_type;

   typedef enum logic [3:0] {
      AR_IDLE,
      AR_FS2,
      AR_VEL_LO,
      AR_VEL_HI,
      AR_VEL_DIV,
      AR_ACC_LO,
      AR_ACC_HI,
      AR_ACC_DIV,
      AR_DONE
   } arith_state_type;

endpackage

// File: sv/sva_arith.sv
// Shared multiplier and radix-4 constant divider that scale and round both derivatives.
`timescale 1ns / 1ps

module sva_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sva_pkg::s1_type               s1,
   input  sva_pkg::s2_type               s2,
   input  logic [sva_pkg::FS_W-1:0]      fs,
   output sva_pkg::arith_res_type        res
);
   import sva_pkg::*;

   arith_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [M1_W-1:0]    m1_ff, m1_in;
   logic [M2_W-1:0]    m2_ff, m2_in;
   logic               neg1_ff, neg1_in;
   logic               neg2_ff, neg2_in;
   logic [MUL_B_W-1:0] fs2_ff, fs2_in;
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic [S1_W-1:0]    s1_abs;
   logic [S2_W-1:0]    s2_abs;
   logic [REM_W-1:0]   dv;
   logic [TRIAL_W-1:0] d1, d2, d3, trial, trial_rem;
   logic [1:0]         qd;
   logic [WORK_W-1:0]  quot;
   logic               done;

   assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign s1_abs = s1[S1_W-1] ? -s1 : s1;
   assign s2_abs = s2[S2_W-1] ? -s2 : s2;

   // one radix-4 quotient digit per cycle
   always_comb begin
      dv    = (state_ff == AR_VEL_DIV) ? VEL_DIV : ACC_DIV;
      d1    = TRIAL_W'(dv);
      d2    = d1 << 1;
      d3    = d1 + d2;
      trial = {rem_ff, work_ff[WORK_W-1 -: 2]};
      if (trial >= d3) begin
         qd = 2'd3;
         trial_rem = trial - d3;
      end else if (trial >= d2) begin
         qd = 2'd2;
         trial_rem = trial - d2;
      end else if (trial >= d1) begin
         qd = 2'd1;
         trial_rem = trial - d1;
      end else begin
         qd = 2'd0;
         trial_rem = trial;
      end
      quot = {work_ff[WORK_W-3:0], qd};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      neg1_in  = neg1_ff;
      neg2_in  = neg2_ff;
      fs2_in   = fs2_ff;
      vel_in   = vel_ff;
      acc_in   = acc_ff;
      mul_a    = '0;
      mul_b    = '0;
      done     = 1'b0;
      case (state_ff)
         AR_IDLE: begin
            if (start) begin
               m1_in    = s1_abs[M1_W-1:0];
               m2_in    = s2_abs[M2_W-1:0];
               neg1_in  = s1[S1_W-1];
               neg2_in  = s2[S2_W-1];
               state_in = AR_FS2;
            end
         end
         AR_FS2: begin
            mul_a    = MUL_A_W'(fs);
            mul_b    = MUL_B_W'(fs);
            fs2_in   = prod[MUL_B_W-1:0];
            state_in = AR_VEL_LO;
         end
         AR_VEL_LO: begin
            mul_a    = m1_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(fs);
            work_in  = VEL_HALF + WORK_W'(prod);
            state_in = AR_VEL_HI;
         end
         AR_VEL_HI: begin
            mul_a    = MUL_A_W'(m1_ff[M1_W-1:MUL_A_W]);
            mul_b    = MUL_B_W'(fs);
            work_in  = work_ff + (WORK_W'(prod) << MUL_A_W);
            rem_in   = '0;
            step_in  = '0;
            state_in = AR_VEL_DIV;
         end
         AR_VEL_DIV: begin
            work_in = quot;
            rem_in  = trial_rem[REM_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               vel_in   = neg1_ff ? -quot[VEL_W-1:0] : quot[VEL_W-1:0];
               state_in = AR_ACC_LO;
            end
         end
         AR_ACC_LO: begin
            mul_a    = m2_ff[MUL_A_W-1:0];
            mul_b    = fs2_ff;
            work_in  = ACC_HALF + WORK_W'(prod);
            state_in = AR_ACC_HI;
         end
         AR_ACC_HI: begin
            mul_a    = MUL_A_W'(m2_ff[M2_W-1:MUL_A_W]);
            mul_b    = fs2_ff;
            work_in  = work_ff + (WORK_W'(prod) << MUL_A_W);
            rem_in   = '0;
            step_in  = '0;
            state_in = AR_ACC_DIV;
         end
         AR_ACC_DIV: begin
            work_in = quot;
            rem_in  = trial_rem[REM_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               acc_in   = neg2_ff ? -quot[ACC_W-1:0] : quot[ACC_W-1:0];
               state_in = AR_DONE;
            end
         end
         AR_DONE: begin
            done     = 1'b1;
            state_in = AR_IDLE;
         end
         default: begin
            state_in = AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      neg1_ff <= neg1_in;
      neg2_ff <= neg2_in;
      fs2_ff  <= fs2_in;
      vel_ff  <= vel_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      res.done         = done;
      res.velocity     = vel_ff;
      res.acceleration = acc_ff;
   end

endmodule

// File: sv/stencil_velocity_acceleration.sv
// Top level: per-channel window memory, push/tap sequencer and result register.
// Flow: a sample's transfer is followed by its push, a check, the tap reads, a launch, the shared
// scaler with its two 32-step radix-4 divisions, and the load of the result register.
// An item pushes its sample once, or five times if it opens a run, plus four copies if final.
// One item at a time: requests stall until the last item is through, and an output stall holds it.
// Reset: synchronous; clears channel counts and the sequencer, rate register returns to 100.
`timescale 1ns / 1ps

module stencil_velocity_acceleration (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sva_pkg::CH_W-1:0]               req_channel,
   input  logic signed [sva_pkg::POS_W-1:0]       req_position,
   input  logic                                   req_final_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sva_pkg::CH_W-1:0]               rsp_out_channel,
   output logic signed [sva_pkg::POS_W-1:0]       rsp_centre_position,
   output logic signed [sva_pkg::VEL_W-1:0]       rsp_velocity,
   output logic signed [sva_pkg::ACC_W-1:0]       rsp_acceleration,
   output logic                                   rsp_run_end,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sva_pkg::FS_W-1:0]               csr_sample_rate_hz
);
   import sva_pkg::*;

   seq_state_type state_ff, state_in;
   logic [FS_W-1:0]   fs_ff;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic signed [POS_W-1:0] x_ff, x_in;
   logic              fin_ff, fin_in;
   logic [CNT_W-1:0]  grp_ff, grp_in;
   logic [CNT_W-1:0]  rep_ff, rep_in;
   logic [SEEN_W-1:0] seen_ff [CHANNELS];
   logic [SEEN_W-1:0] seen_in [CHANNELS];
   logic [SLOT_W-1:0] wptr_ff [CHANNELS];
   logic [SLOT_W-1:0] wptr_in [CHANNELS];
   logic [SLOT_W-1:0] tap_ff, tap_in;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   logic signed [POS_W-1:0] centre_ff, centre_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_ch_ff, rsp_ch_in;
   logic signed [POS_W-1:0] rsp_centre_ff, rsp_centre_in;
   logic signed [VEL_W-1:0] rsp_vel_ff, rsp_vel_in;
   logic signed [ACC_W-1:0] rsp_acc_ff, rsp_acc_in;
   logic              rsp_end_ff, rsp_end_in;

   logic [POS_W-1:0]  win_mem [MEM_DEPTH];
   logic signed [POS_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;

   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] tap_slot;
   logic [SLOT_W-1:0] idx;
   logic              ch_ok;
   logic              arith_start;
   arith_res_type     arith_res;

   assign ch_ok    = (int'(req_channel) < CHANNELS);
   assign slot_sum = (SLOT_W+1)'(wptr_ff[ch_ff]) + (SLOT_W+1)'(tap_ff);
   assign tap_slot = (slot_sum >= (SLOT_W+1)'(WIN)) ? SLOT_W'(slot_sum - (SLOT_W+1)'(WIN))
                                                    : slot_sum[SLOT_W-1:0];
   assign idx      = tap_ff - 1'b1;
   assign rd_addr  = {ch_ff, tap_slot};
   assign wr_addr  = {ch_ff, wptr_ff[ch_ff]};

   sva_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (arith_start),
      .s1    (s1_ff),
      .s2    (s2_ff),
      .fs    (fs_ff),
      .res   (arith_res)
   );

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      fin_in        = fin_ff;
      grp_in        = grp_ff;
      rep_in        = rep_ff;
      seen_in       = seen_ff;
      wptr_in       = wptr_ff;
      tap_in        = tap_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      centre_in     = centre_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ch_in     = rsp_ch_ff;
      rsp_centre_in = rsp_centre_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_end_in    = rsp_end_ff;
      wr_en         = 1'b0;
      arith_start   = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ch_in  = req_channel;
               x_in   = req_position;
               fin_in = req_final_sample;
               if (ch_ok) begin
                  grp_in   = (seen_ff[req_channel] == '0) ? HEAD_COPIES : CNT_W'(1);
                  rep_in   = req_final_sample ? TAIL_COPIES : '0;
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            wr_en = 1'b1;
            wptr_in[ch_ff] = (wptr_ff[ch_ff] == SLOT_LAST) ? '0 : wptr_ff[ch_ff] + 1'b1;
            if (seen_ff[ch_ff] != SEEN_FULL) begin
               seen_in[ch_ff] = seen_ff[ch_ff] + 1'b1;
            end
            grp_in = grp_ff - 1'b1;
            if (grp_ff == CNT_W'(1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (seen_ff[ch_ff] == SEEN_FULL) begin
               tap_in   = '0;
               s1_in    = '0;
               s2_in    = '0;
               state_in = ST_TAP;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_TAP: begin
            // read data is registered and trails the tap counter, so it belongs to tap idx
            tap_in = tap_ff + 1'b1;
            if (tap_ff != '0) begin
               s1_in = s1_ff + S1_W'(rd_data_ff) * S1_W'(VEL_COEF[idx]);
               s2_in = s2_ff + S2_W'(rd_data_ff) * S2_W'(ACC_COEF[idx]);
               if (idx == CENTRE_TAP) begin
                  centre_in = rd_data_ff;
               end
            end
            if (tap_ff == SLOT_W'(WIN)) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            arith_start = 1'b1;
            state_in    = ST_ARITH;
         end
         ST_ARITH: begin
            if (arith_res.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = ch_ff;
               rsp_centre_in = centre_ff;
               rsp_vel_in    = arith_res.velocity;
               rsp_acc_in    = arith_res.acceleration;
               rsp_end_in    = fin_ff && (rep_ff == '0);
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (rep_ff != '0) begin
               rep_in   = rep_ff - 1'b1;
               grp_in   = CNT_W'(1);
               state_in = ST_PUSH;
            end else begin
               if (fin_ff) begin
                  seen_in[ch_ff] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fs_ff        <= FS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            seen_ff[c] <= '0;
            wptr_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         wptr_ff      <= wptr_in;
         if (csr_valid && csr_ready) begin
            fs_ff <= csr_sample_rate_hz;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      x_ff          <= x_in;
      fin_ff        <= fin_in;
      grp_ff        <= grp_in;
      rep_ff        <= rep_in;
      tap_ff        <= tap_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      centre_ff     <= centre_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_centre_ff <= rsp_centre_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // window store: circular buffer per channel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wr_addr] <= x_ff;
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_channel     = rsp_ch_ff;
   assign rsp_centre_position = rsp_centre_ff;
   assign rsp_velocity        = rsp_vel_ff;
   assign rsp_acceleration    = rsp_acc_ff;
   assign rsp_run_end         = rsp_end_ff;

endmodule

// File: bench/tb_stencil_velocity_acceleration.sv
// Testbench for the nine-tap stencil differentiator: directed edge runs plus random traffic.
`timescale 1ns / 1ps

module tb_stencil_velocity_acceleration;
   import sva_pkg::*;

   typedef struct {
      logic [CH_W-1:0]         channel;
      logic signed [POS_W-1:0] centre;
      logic signed [VEL_W-1:0] velocity;
      logic signed [ACC_W-1:0] acceleration;
      logic                    run_end;
   } motion_result_type;

   localparam longint SECOND_DIFF_TAPS [WIN] = '{1, -16, 64, 16, -130, 16, 64, -16, 1};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CH_W-1:0]         req_channel = '0;
   logic signed [POS_W-1:0] req_position = '0;
   logic                    req_final_sample = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CH_W-1:0]         rsp_out_channel;
   logic signed [POS_W-1:0] rsp_centre_position;
   logic signed [VEL_W-1:0] rsp_velocity;
   logic signed [ACC_W-1:0] rsp_acceleration;
   logic                    rsp_run_end;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [FS_W-1:0]         csr_sample_rate_hz = '0;

   motion_result_type       expected_motion_q [$];
   longint                  tap_window [CHANNELS][WIN];
   int unsigned             padded_count [CHANNELS];
   logic [FS_W-1:0]         rate_hz = FS_RESET;
   int unsigned             run_left [CHANNELS];
   logic signed [POS_W-1:0] trace_pos [CHANNELS] = '{default: '0};

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;

   stencil_velocity_acceleration u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_channel         (req_channel),
      .req_position        (req_position),
      .req_final_sample    (req_final_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_centre_position (rsp_centre_position),
      .rsp_velocity        (rsp_velocity),
      .rsp_acceleration    (rsp_acceleration),
      .rsp_run_end         (rsp_run_end),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_sample_rate_hz  (csr_sample_rate_hz)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic longint round_nearest(input longint num, input longint den);
      longint half;
      half = den / 2;
      if (num >= 0)
         return (num + half) / den;
      return -((-num + half) / den);
   endfunction

   function automatic void push_tap(input logic [CH_W-1:0] ch, input longint x);
      int i;
      for (i = 0; i < WIN - 1; i++)
         tap_window[ch][i] = tap_window[ch][i + 1];
      tap_window[ch][WIN - 1] = x;
      if (padded_count[ch] < WIN)
         padded_count[ch]++;
   endfunction

   function automatic void queue_motion(input logic [CH_W-1:0] ch, input logic last);
      motion_result_type r;
      longint fs, d1, d2;
      int i;
      fs = longint'(rate_hz);
      d1 = tap_window[ch][2] - 8 * tap_window[ch][3] + 8 * tap_window[ch][5]
           - tap_window[ch][6];
      d2 = 0;
      for (i = 0; i < WIN; i++)
         d2 += SECOND_DIFF_TAPS[i] * tap_window[ch][i];
      r.channel      = ch;
      r.centre       = POS_W'(tap_window[ch][4]);
      r.velocity     = VEL_W'(round_nearest(d1 * fs, 12));
      r.acceleration = ACC_W'(round_nearest(d2 * (fs * fs), 144));
      r.run_end      = last;
      expected_motion_q.push_back(r);
   endfunction

   // edge padding: first sample written five times, final one followed by four copies
   function automatic void predict_motion(input logic [CH_W-1:0] ch,
                                          input logic signed [POS_W-1:0] pos,
                                          input logic fin);
      longint x;
      int r;
      x = longint'(pos);
      if (padded_count[ch] == 0) begin
         for (r = 0; r < 5; r++)
            push_tap(ch, x);
      end else begin
         push_tap(ch, x);
      end
      if (padded_count[ch] == WIN)
         queue_motion(ch, 1'b0);
      if (fin) begin
         for (r = 0; r < 4; r++) begin
            push_tap(ch, x);
            if (padded_count[ch] == WIN)
               queue_motion(ch, r == 3);
         end
         padded_count[ch] = 0;
      end
   endfunction

   task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [POS_W-1:0] pos,
                              input logic fin);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_channel      <= ch;
      req_position     <= pos;
      req_final_sample <= fin;
      do @(posedge clock); while (req_stall);
      predict_motion(ch, pos, fin);
      items_sent++;
   endtask

   task automatic write_rate(input logic [FS_W-1:0] rate);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_sample_rate_hz <= rate;
      do @(posedge clock); while (!csr_ready);
      rate_hz = rate;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // a sample that yields no result may still be in flight, so hold off past one item time
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_motion_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   always @(posedge clock) begin
      motion_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_motion_q.size() == 0) begin
            $error("unexpected result transfer on channel %0d", rsp_out_channel);
            error_count++;
         end else begin
            want = expected_motion_q.pop_front();
            results_checked++;
            if (rsp_out_channel !== want.channel) begin
               $error("out_channel: expected %0d, got %0d", want.channel, rsp_out_channel);
               error_count++;
            end
            if (rsp_centre_position !== want.centre) begin
               $error("centre_position: expected %0d, got %0d", want.centre,
                      rsp_centre_position);
               error_count++;
            end
            if (rsp_velocity !== want.velocity) begin
               $error("velocity: expected %0d, got %0d", want.velocity, rsp_velocity);
               error_count++;
            end
            if (rsp_acceleration !== want.acceleration) begin
               $error("acceleration: expected %0d, got %0d", want.acceleration,
                      rsp_acceleration);
               error_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_run_end);
               error_count++;
            end
         end
      end
   end

   function automatic int unsigned pick_run_length();
      case ($urandom_range(9))
         0:       return 1;
         1, 2, 3,
         4, 5, 6: return $urandom_range(2, 12);
         default: return $urandom_range(13, 30);
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] pick_position(input logic [CH_W-1:0] ch);
      logic signed [POS_W-1:0] p;
      case ($urandom_range(5))
         0: p = $urandom;
         1: p = $signed($urandom_range(8_000_000)) - 32'sd4_000_000;
         2: begin
            case ($urandom_range(3))
               0:       p = 32'sh7FFF_FFFF;
               1:       p = 32'sh8000_0000;
               2:       p = '0;
               default: p = -32'sd1;
            endcase
         end
         default: p = trace_pos[ch] + $signed($urandom_range(200_000)) - 32'sd100_000;
      endcase
      trace_pos[ch] = p;
      return p;
   endfunction

   // one-sample trajectories at the position extremes and zero, reset rate
   task automatic test_single_sample_runs();
      send_sample(3'd0, 32'sh7FFF_FFFF, 1'b1);
      send_sample(3'd7, 32'sh8000_0000, 1'b1);
      send_sample(3'd3, 32'sd0, 1'b1);
   endtask

   // interleaved trajectories of two to five samples
   task automatic test_short_runs();
      logic signed [POS_W-1:0] ladder [5];
      int step, c;
      ladder = '{32'sd0, -32'sd1, 32'sh0001_0000, -32'sh0003_4000, 32'sh7FFF_FFF0};
      for (step = 0; step < 5; step++) begin
         for (c = 1; c <= 4; c++) begin
            if (step <= c)
               send_sample(CH_W'(c), ladder[step] + c, step == c);
         end
      end
   endtask

   // largest rate against alternating full-scale swings, then rate zero
   task automatic test_rate_extremes();
      int n;
      wait_until_idle();
      write_rate(11'd2047);
      for (n = 0; n < 6; n++)
         send_sample(3'd5, n[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF, n == 5);
      wait_until_idle();
      write_rate(11'd0);
      send_sample(3'd6, 32'sh1234_5678, 1'b0);
      send_sample(3'd6, -32'sh0765_4321, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [FS_W-1:0] rate, input int n_items);
      logic [CH_W-1:0] ch;
      logic fin;
      int n;
      wait_until_idle();
      write_rate(rate);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < n_items; n++) begin
         ch = CH_W'($urandom_range(CHANNELS - 1));
         if (run_left[ch] == 0)
            run_left[ch] = pick_run_length();
         fin = (run_left[ch] == 1);
         run_left[ch]--;
         send_sample(ch, pick_position(ch), fin);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_single_sample_runs();
      test_short_runs();
      test_rate_extremes();
      test_random_traffic(0, 0, 11'd1100, 37);
      test_random_traffic(62, 0, 11'd1, 37);
      test_random_traffic(0, 62, FS_W'($urandom_range(2, 1099)), 37);
      test_random_traffic(33, 33, 11'd2047, 37);
      wait_until_idle();
      $display("Sent %0d samples over 8 channels, checked %0d results", items_sent,
               results_checked);
      $display("Rates 0 to 2047, runs of 1 to 30 samples, four idle/stall mixes");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
